>>> src/cas_pkg.sv
package cas_pkg;

    // Size limits used as parameter defaults
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register field widths
    localparam int GW_W       = 8;
    localparam int GH_W       = 11;
    localparam int LIM_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Neighbor count holds 0..8
    localparam int CNT_W = 4;

    // One window column: bit 0 oldest row, bit 1 middle row, bit 2 newest row
    localparam int COL_BITS = 3;
    localparam int WIN_COLS = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_BIRTH_LIMIT = 2'd2,
        REG_DEATH_LIMIT = 2'd3
    } cfg_reg_t;

    localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 8'd100;
    localparam logic [GH_W-1:0]  GRID_HEIGHT_RST = 11'd45;
    localparam logic [LIM_W-1:0] BIRTH_LIMIT_RST = 4'd4;
    localparam logic [LIM_W-1:0] DEATH_LIMIT_RST = 4'd3;

    // How the rule unit looks at the window for one result
    typedef struct packed {
        logic colsh;       // view one column to the right
        logic rowsh;       // view one row down
        logic wall_top;
        logic wall_bot;
        logic wall_left;
        logic wall_right;
    } view_t;

endpackage

>>> src/cas_col_cell.sv
module cas_col_cell
    import cas_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [COL_BITS-1:0] col_in,
    output logic [COL_BITS-1:0] col_out
);

    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;

    // Take the column from the right-hand neighbor on each shift
    assign col_next = shift_en ? col_in : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

>>> src/cas_line_store.sv
module cas_line_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);

    // bit 0: previous row, bit 1: row before that
    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;
    logic [1:0] rd_data_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward a same-address write so the read never sees stale data
    always_ff @(posedge aclk) begin
        rd_data_reg <= rd_data_next;
    end

    always_comb begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_next = wr_data;
        end else begin
            rd_data_next = mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/cas_rule.sv
module cas_rule
    import cas_pkg::*;
(
    input  logic [WIN_COLS-1:0][COL_BITS-1:0] win,
    input  view_t                             view,
    input  logic [LIM_W-1:0]                  birth_limit,
    input  logic [LIM_W-1:0]                  death_limit,
    output logic                              cell_next
);

    function automatic logic [COL_BITS-1:0] row_view(input logic [COL_BITS-1:0] b,
                                                     input logic rowsh);
        return rowsh ? {1'b1, b[2], b[1]} : b;
    endfunction

    logic [COL_BITS-1:0] v0, v1, v2;
    logic [CNT_W-1:0]    cnt;

    always_comb begin
        // Shift the view right and down as asked; past the window reads as wall
        v0 = row_view(view.colsh ? win[1] : win[0], view.rowsh);
        v1 = row_view(view.colsh ? win[2] : win[1], view.rowsh);
        v2 = row_view(view.colsh ? {COL_BITS{1'b1}} : win[2], view.rowsh);

        // Force grid borders to wall
        if (view.wall_top) begin
            v0[0] = 1'b1;
            v1[0] = 1'b1;
            v2[0] = 1'b1;
        end
        if (view.wall_bot) begin
            v0[2] = 1'b1;
            v1[2] = 1'b1;
            v2[2] = 1'b1;
        end
        if (view.wall_left) begin
            v0 = {COL_BITS{1'b1}};
        end
        if (view.wall_right) begin
            v2 = {COL_BITS{1'b1}};
        end

        cnt = CNT_W'(v0[0]) + CNT_W'(v0[1]) + CNT_W'(v0[2])
            + CNT_W'(v1[0]) + CNT_W'(v1[2])
            + CNT_W'(v2[0]) + CNT_W'(v2[1]) + CNT_W'(v2[2]);

        if (v1[1]) begin
            cell_next = (cnt >= death_limit);
        end else begin
            cell_next = (cnt > birth_limit);
        end
    end

endmodule

>>> src/cave_automaton_smoothing_pass_core.sv
// Channel   Dir  Handshake            Beat contents
// s_        in   s_valid / s_ready    s_cell_in: one grid cell, raster order
// m_        out  m_valid / m_ready    m_cell_out, m_out_col, m_out_row, m_frame_last
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data: one register write
//
// Cycles: while m_ready is high, one input beat per cycle if it yields at most one
// result, and one result beat a cycle from the emitter. An input that yields more
// holds the emitter until all go out: two at a row end, up to four at frame end.
// Reset: aresetn synchronous, active low; counters, pending results and registers
// return to their defaults. The line store needs no clearing pass.
// Stalls: a low m_ready holds the result register full; a new input beat is taken
// while no result is owed, or while one is owed and the result register is free or
// emptying in the same cycle.
module cave_automaton_smoothing_pass_core
    import cas_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cell_in,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_cell_out,
    output logic [CW-1:0]         m_out_col,
    output logic [RW-1:0]         m_out_row,
    output logic                  m_frame_last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CCMP_W = (CW + 1 > GW_W) ? CW + 1 : GW_W;
    localparam int RCMP_W = (RW + 1 > GH_W) ? RW + 1 : GH_W;

    // Result slots; bit 0 of the code shifts the view right, bit 1 down
    typedef enum logic [1:0] {
        SLOT_UP_LEFT = 2'd0,   // cell one row up, one column left
        SLOT_UP_HERE = 2'd1,   // cell one row up, this column
        SLOT_LEFT    = 2'd2,   // cell in this row, one column left
        SLOT_CORNER  = 2'd3    // this cell, closes the frame
    } slot_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GW_W-1:0]  grid_width_reg;
    logic [GH_W-1:0]  grid_height_reg;
    logic [LIM_W-1:0] birth_limit_reg;
    logic [LIM_W-1:0] death_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            birth_limit_reg <= BIRTH_LIMIT_RST;
            death_limit_reg <= DEATH_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_W-1:0];
                REG_BIRTH_LIMIT: birth_limit_reg <= cfg_data[LIM_W-1:0];
                REG_DEATH_LIMIT: death_limit_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Raster position of the next input beat
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW:0]   col_plus;
    logic [RW:0]   row_plus;
    logic          is_end, is_last;
    logic          in_acc;

    assign in_acc   = s_valid && s_ready;
    assign col_plus = {1'b0, col_reg} + 1'b1;
    assign row_plus = {1'b0, row_reg} + 1'b1;

    // A zero size clamps to one; a size past the maximum clamps to the maximum.
    // A counter beyond a shrunken size counts as being at the last position.
    assign is_end  = (CCMP_W'(col_plus) >= CCMP_W'(grid_width_reg))
                  || (col_plus >= (CW + 1)'(MAX_WIDTH));
    assign is_last = (RCMP_W'(row_plus) >= RCMP_W'(grid_height_reg))
                  || (row_plus >= (RW + 1)'(MAX_HEIGHT));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc) begin
            if (is_end) begin
                col_next = '0;
                row_next = is_last ? '0 : row_plus[RW-1:0];
            end else begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: prefetch the entry for the next column every cycle
    // ------------------------------------------------------------------
    logic [1:0] st_rd;

    cas_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_acc),
        .wr_addr (col_reg),
        .wr_data ({st_rd[0], s_cell_in}),
        .rd_addr (col_next),
        .rd_data (st_rd)
    );

    // ------------------------------------------------------------------
    // Window: a chain of three column cells, newest on the right
    // ------------------------------------------------------------------
    logic [WIN_COLS-1:0][COL_BITS-1:0] win_col;
    logic [COL_BITS-1:0]               new_col;

    assign new_col = {s_cell_in, st_rd[0], st_rd[1]};

    for (genvar gi = 0; gi < WIN_COLS; gi++) begin : g_cells
        logic [COL_BITS-1:0] col_src;

        if (gi == WIN_COLS - 1) begin : g_head
            assign col_src = new_col;
        end else begin : g_link
            assign col_src = win_col[gi + 1];
        end

        cas_col_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (in_acc),
            .col_in   (col_src),
            .col_out  (win_col[gi])
        );
    end

    // ------------------------------------------------------------------
    // Job: the results owed by the last accepted beat
    // ------------------------------------------------------------------
    logic [3:0]    pend_reg, pend_next, pend_new;
    logic [CW-1:0] job_col_reg;
    logic [RW-1:0] job_row_reg;
    logic          job_r_eq0_reg, job_r_eq1_reg, job_c_eq0_reg, job_c_eq1_reg;

    always_comb begin
        pend_new               = '0;
        pend_new[SLOT_UP_LEFT] = (row_reg != '0) && (col_reg != '0);
        pend_new[SLOT_UP_HERE] = (row_reg != '0) && is_end;
        pend_new[SLOT_LEFT]    = is_last && (col_reg != '0);
        pend_new[SLOT_CORNER]  = is_last && is_end;
    end

    // Hold the job position until the next accept; no reset on payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            job_col_reg   <= col_reg;
            job_row_reg   <= row_reg;
            job_r_eq0_reg <= (row_reg == '0);
            job_r_eq1_reg <= (row_reg == RW'(1));
            job_c_eq0_reg <= (col_reg == '0);
            job_c_eq1_reg <= (col_reg == CW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Emitter: lowest pending slot goes out first
    // ------------------------------------------------------------------
    slot_t sel;
    view_t view;
    logic  out_free, out_load, cell_next;

    always_comb begin
        if (pend_reg[SLOT_UP_LEFT]) begin
            sel = SLOT_UP_LEFT;
        end else if (pend_reg[SLOT_UP_HERE]) begin
            sel = SLOT_UP_HERE;
        end else if (pend_reg[SLOT_LEFT]) begin
            sel = SLOT_LEFT;
        end else begin
            sel = SLOT_CORNER;
        end
    end

    always_comb begin
        view.colsh      = sel[0];
        view.rowsh      = sel[1];
        view.wall_top   = sel[1] ? job_r_eq0_reg : job_r_eq1_reg;
        view.wall_bot   = sel[1];
        view.wall_left  = sel[0] ? job_c_eq0_reg : job_c_eq1_reg;
        view.wall_right = sel[0];
    end

    cas_rule u_rule (
        .win         (win_col),
        .view        (view),
        .birth_limit (birth_limit_reg),
        .death_limit (death_limit_reg),
        .cell_next   (cell_next)
    );

    logic          m_valid_reg, m_valid_next;
    logic          cell_out_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic          frame_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (pend_reg != '0) && out_free;

    // Take a new beat once the job drains this cycle or is already empty
    assign s_ready = (pend_reg == '0)
                  || (((pend_reg & (pend_reg - 4'd1)) == '0) && out_free);

    always_comb begin
        pend_next = pend_reg;
        if (in_acc) begin
            pend_next = pend_new;
        end else if (out_load) begin
            pend_next[sel] = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            cell_out_reg   <= cell_next;
            out_col_reg    <= sel[0] ? job_col_reg : job_col_reg - 1'b1;
            out_row_reg    <= sel[1] ? job_row_reg : job_row_reg - 1'b1;
            frame_last_reg <= (sel == SLOT_CORNER);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_out   = cell_out_reg;
    assign m_out_col    = out_col_reg;
    assign m_out_row    = out_row_reg;
    assign m_frame_last = frame_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_accept_with_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(pend_reg) > 1) |-> !s_ready)
        else $error("input taken while two or more results still pending");

    a_frame_end_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && is_last && is_end) |=> pend_reg[SLOT_CORNER])
        else $error("last cell of the grid did not queue its closing result");

    a_job_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && $onehot(pend_reg) && !in_acc) |=> (pend_reg == '0))
        else $error("job did not drain after its last result");

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

>>> sim/cave_automaton_smoothing_pass_core_tb.sv
module cave_automaton_smoothing_pass_core_tb;
    import cas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = $clog2(MAX_WIDTH_DEF);
    localparam int RW          = $clog2(MAX_HEIGHT_DEF);
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 8;

    // One result beat as the block should present it
    typedef struct packed {
        logic          wall;
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          last;
    } cave_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cell_in;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_cell_out;
    logic [CW-1:0]         m_out_col;
    logic [RW-1:0]         m_out_row;
    logic                  m_frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cave_automaton_smoothing_pass_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_in   (s_cell_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_out  (m_cell_out),
        .m_out_col   (m_out_col),
        .m_out_row   (m_out_row),
        .m_frame_last(m_frame_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Shadow of the block: register copies, line stores, window and raster position
    logic [GW_W-1:0]  cfg_width  = GRID_WIDTH_RST;
    logic [GH_W-1:0]  cfg_height = GRID_HEIGHT_RST;
    logic [LIM_W-1:0] cfg_birth  = BIRTH_LIMIT_RST;
    logic [LIM_W-1:0] cfg_death  = DEATH_LIMIT_RST;
    logic             line_prev  [MAX_WIDTH_DEF] = '{default: 1'b0};
    logic             line_prev2 [MAX_WIDTH_DEF] = '{default: 1'b0};
    logic [8:0]       smooth_window = '0;
    logic [CW-1:0]    col_pos = '0;
    logic [RW-1:0]    row_pos = '0;

    cave_result_t expected_cells[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int in_gap_max    = 11;
    int out_gap_max   = 11;
    int hold_request  = 0;
    int random_items  = 0;

    // Clock and watchdog
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Clamp the size registers the way the block does
    function automatic int effective_width();
        if (cfg_width < 1) return 1;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(cfg_width);
    endfunction

    function automatic int effective_height();
        if (cfg_height < 1) return 1;
        if (cfg_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return int'(cfg_height);
    endfunction

    // Apply the birth/death rule to one view of the 3x3 window.
    // Window columns: [8:6] left, [5:3] middle, [2:0] right; inside a column
    // bit 0 is the oldest row. Anything shifted out of the window, or forced
    // by a grid edge, reads as wall.
    function automatic logic next_generation(input logic [8:0] win, input view_t v);
        logic [2:0] grid [3];
        logic [2:0] colbits;
        int         r, c, sc, sr, cnt;
        cnt = 0;
        for (c = 0; c < 3; c++) begin
            sc = c + int'(v.colsh);
            colbits = (sc <= 2) ? win[(6 - 3 * sc) +: 3] : 3'b111;
            for (r = 0; r < 3; r++) begin
                sr = r + int'(v.rowsh);
                grid[r][c] = (sr <= 2) ? colbits[sr] : 1'b1;
            end
        end
        for (c = 0; c < 3; c++) begin
            if (v.wall_top) grid[0][c] = 1'b1;
            if (v.wall_bot) grid[2][c] = 1'b1;
        end
        for (r = 0; r < 3; r++) begin
            if (v.wall_left)  grid[r][0] = 1'b1;
            if (v.wall_right) grid[r][2] = 1'b1;
        end
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                if (!(r == 1 && c == 1)) cnt += int'(grid[r][c]);
        if (grid[1][1]) return (cnt >= int'(cfg_death));
        return (cnt > int'(cfg_birth));
    endfunction

    task automatic expect_cell(input logic wall, input int col, input int row, input logic last);
        expected_cells.push_back(cave_result_t'{wall, CW'(col), RW'(row), last});
    endtask

    // Advance the shadow by one accepted cell and queue the results it releases
    task automatic advance_smoothing(input logic cell_bit);
        int   w, h, c, r;
        logic at_end, at_last;
        w = effective_width();
        h = effective_height();
        c = int'(col_pos);
        r = int'(row_pos);
        at_end  = (c >= w - 1);
        at_last = (r >= h - 1);

        smooth_window = {smooth_window[5:0], cell_bit, line_prev[c], line_prev2[c]};

        // Cell up and left of the input: its window just closed
        if (r >= 1 && c >= 1)
            expect_cell(next_generation(smooth_window,
                view_t'{1'b0, 1'b0, r == 1, 1'b0, c == 1, 1'b0}), c - 1, r - 1, 1'b0);
        // Row end: flush the cell straight above
        if (r >= 1 && at_end)
            expect_cell(next_generation(smooth_window,
                view_t'{1'b1, 1'b0, r == 1, 1'b0, c == 0, 1'b1}), c, r - 1, 1'b0);
        // Last row: cells of the current row close against the bottom wall
        if (at_last && c >= 1)
            expect_cell(next_generation(smooth_window,
                view_t'{1'b0, 1'b1, r == 0, 1'b1, c == 1, 1'b0}), c - 1, r, 1'b0);
        if (at_last && at_end)
            expect_cell(next_generation(smooth_window,
                view_t'{1'b1, 1'b1, r == 0, 1'b1, c == 0, 1'b1}), c, r, 1'b1);

        line_prev2[c] = line_prev[c];
        line_prev[c]  = cell_bit;

        if (at_end) begin
            col_pos = '0;
            row_pos = at_last ? '0 : RW'(r + 1);
        end else begin
            col_pos = CW'(c + 1);
        end
    endtask

    // Cells still to send before the current frame closes
    function automatic int items_to_frame_end();
        int w, h, n;
        w = effective_width();
        h = effective_height();
        n = (int'(col_pos) >= w - 1) ? 1 : w - int'(col_pos);
        if (int'(row_pos) < h - 1) n += (h - 1 - int'(row_pos)) * w;
        return n;
    endfunction

    // Offer one cell after a random gap; hold valid until the beat is taken
    task automatic send_cell(input logic cell_bit);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_cell_in <= cell_bit;
        do @(posedge aclk); while (!s_ready);
        advance_smoothing(cell_bit);
    endtask

    task automatic send_cells(input int count, input int wall_pct);
        repeat (count) send_cell($urandom_range(0, 99) < wall_pct);
    endtask

    // Send a fixed pattern, bit 0 first
    task automatic send_pattern(input int count, input logic [8:0] bits);
        int i;
        for (i = 0; i < count; i++) send_cell(bits[i]);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GRID_WIDTH:  cfg_width  = value[GW_W-1:0];
            REG_GRID_HEIGHT: cfg_height = value[GH_W-1:0];
            REG_BIRTH_LIMIT: cfg_birth  = value[LIM_W-1:0];
            REG_DEATH_LIMIT: cfg_death  = value[LIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid right after the last beat, drain every expected result,
    // then let the pipeline go quiet before touching the registers.
    task automatic wait_idle(input int settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_reg_t idx);
        case (idx)
            REG_GRID_WIDTH:
                return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 20))
                                                   : CFG_DATA_W'($urandom_range(2, 9));
            REG_GRID_HEIGHT:
                return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 8))
                                                   : CFG_DATA_W'($urandom_range(1, 5));
            default:
                return ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(9, 15))
                                                   : CFG_DATA_W'($urandom_range(0, 8));
        endcase
    endfunction

    // Widest grid any later test uses, for two rows: fills both line stores
    // at every column in use, so no later frame reads an unwritten entry. Run
    // it back to back on both sides, with the limits still at their reset values.
    task automatic test_line_store_fill();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd20);
        write_reg(REG_GRID_HEIGHT, 11'd2);
        in_gap_max  = 0;
        out_gap_max = 0;
        send_cells(items_to_frame_end(), 50);
        wait_idle(SETTLE);
        in_gap_max  = 11;
        out_gap_max = 11;
    endtask

    // Tiny grids where the outside wall dominates, at the limit extremes
    task automatic test_small_grid_rules();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd2);
        write_reg(REG_GRID_HEIGHT, 11'd2);
        write_reg(REG_BIRTH_LIMIT, 11'd0);
        write_reg(REG_DEATH_LIMIT, 11'd0);
        send_pattern(4, 9'b0_0000_0000);   // all open: every cell is born
        wait_idle(SETTLE);
        write_reg(REG_BIRTH_LIMIT, 11'd8);
        write_reg(REG_DEATH_LIMIT, 11'd8);
        send_pattern(4, 9'b0_0000_1111);   // all wall: count 8 keeps them
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd3);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        write_reg(REG_BIRTH_LIMIT, 11'd4);
        write_reg(REG_DEATH_LIMIT, 11'd3);
        send_pattern(9, 9'b0_0001_0000);   // lone center wall
        wait_idle(SETTLE);
        write_reg(REG_BIRTH_LIMIT, 11'd5);
        write_reg(REG_DEATH_LIMIT, 11'd7);
        send_pattern(9, 9'b1_0110_1011);
        wait_idle(SETTLE);
    endtask

    // Zero sizes clamp to one: single-cell frames, then a one-column grid
    task automatic test_size_clamp_low();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd0);
        write_reg(REG_GRID_HEIGHT, 11'd0);
        send_pattern(2, 9'b0_0000_0001);
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd1);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        send_pattern(3, 9'b0_0000_0010);
        wait_idle(SETTLE);
    endtask

    // Limits past 8 clear every wall and block every birth
    task automatic test_limits_above_eight();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd3);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        write_reg(REG_BIRTH_LIMIT, 11'd9);
        write_reg(REG_DEATH_LIMIT, 11'd15);
        send_cells(9, 60);
        wait_idle(SETTLE);
        write_reg(REG_BIRTH_LIMIT, 11'd15);
        write_reg(REG_DEATH_LIMIT, 11'd9);
        send_cells(9, 60);
        wait_idle(SETTLE);
    endtask

    // Resize between beats of one frame: shrink below the current column,
    // grow again, and cut the height under the current row.
    task automatic test_size_change_mid_frame();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd6);
        write_reg(REG_GRID_HEIGHT, 11'd4);
        write_reg(REG_BIRTH_LIMIT, 11'd3);
        write_reg(REG_DEATH_LIMIT, 11'd4);
        send_cells(8, 50);
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd3);
        send_cells(5, 50);
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd7);
        send_cells(4, 50);
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd2);
        send_cells(3, 50);
        wait_idle(SETTLE);
        write_reg(REG_GRID_HEIGHT, 11'd2);
        send_cells(items_to_frame_end(), 50);
        wait_idle(SETTLE);
    endtask

    // Height register all ones clamps to the tallest grid, so a few rows of
    // one cell must not close the frame; then cut the height under the
    // current row so the next beat closes it.
    task automatic test_tall_column();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd0);
        write_reg(REG_GRID_HEIGHT, 11'd2047);
        write_reg(REG_BIRTH_LIMIT, 11'd2);
        write_reg(REG_DEATH_LIMIT, 11'd5);
        send_cells(6, 45);
        wait_idle(SETTLE);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        send_cells(items_to_frame_end(), 45);
        wait_idle(SETTLE);
    endtask

    // Stall the result side for a long stretch while cells keep coming,
    // so the block backs up and drops s_ready.
    task automatic test_output_backpressure();
        wait_idle(SETTLE);
        write_reg(REG_GRID_WIDTH, 11'd4);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        write_reg(REG_BIRTH_LIMIT, 11'd4);
        write_reg(REG_DEATH_LIMIT, 11'd3);
        in_gap_max   = 0;
        hold_request = 300;
        send_cells(24, 50);
        wait_idle(SETTLE);
        in_gap_max = 11;
    endtask

    // Random sizes and limits; mostly whole frames, sometimes a fragment
    // that leaves the next setting to start mid-frame.
    task automatic test_random_frames();
        int       count, wall_pct, writes;
        cfg_reg_t idx;
        random_items = 0;
        while (random_items < 60) begin
            wait_idle(SETTLE);
            in_gap_max  = ($urandom_range(0, 5) == 0) ? 0 : 11;
            out_gap_max = ($urandom_range(0, 5) == 0) ? 0 : 11;
            writes = $urandom_range(1, 4);
            repeat (writes) begin
                idx = cfg_reg_t'($urandom_range(0, 3));
                write_reg(idx, pick_reg_value(idx));
            end
            if ($urandom_range(0, 3) != 0) count = items_to_frame_end();
            else count = $urandom_range(1, 12);
            if (count > 60) count = $urandom_range(1, 20);
            wall_pct = $urandom_range(0, 100);
            send_cells(count, wall_pct);
            random_items += count;
        end
        in_gap_max  = 11;
        out_gap_max = 11;
    endtask

    // Result side: random ready gaps, compare every beat with the oldest expectation
    initial begin : result_sink
        cave_result_t want;
        int           gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = (hold_request > 0) ? hold_request : $urandom_range(0, out_gap_max);
            hold_request = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected beat col %0d row %0d",
                                          m_out_col, m_out_row));
            end else begin
                want = expected_cells.pop_front();
                if (m_cell_out !== want.wall)
                    report_mismatch($sformatf("cell_out %0b want %0b at col %0d row %0d",
                                              m_cell_out, want.wall, want.col, want.row));
                if (m_out_col !== want.col)
                    report_mismatch($sformatf("out_col %0d want %0d", m_out_col, want.col));
                if (m_out_row !== want.row)
                    report_mismatch($sformatf("out_row %0d want %0d", m_out_row, want.row));
                if (m_frame_last !== want.last)
                    report_mismatch($sformatf("frame_last %0b want %0b at col %0d row %0d",
                                              m_frame_last, want.last, want.col, want.row));
            end
        end
    end

    // Main sequence
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cell_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_line_store_fill();
        test_small_grid_rules();
        test_size_clamp_low();
        test_limits_above_eight();
        test_size_change_mid_frame();
        test_tall_column();
        test_output_backpressure();
        test_random_frames();

        // Drain, then watch a while longer for stray beats
        wait_idle(32);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
